[rtl/gha_pkg.sv]
`default_nettype none

package gha_pkg;

  // Default table geometry
  localparam int ID_BITS_DEF  = 8;
  localparam int GEN_BITS_DEF = 8;

  // Fixed field widths
  localparam int ACTION_W    = 2;
  localparam int HANDLE_W    = 16;
  localparam int TAG_W       = 8;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_ALIVE  = 2'd2,
    ACT_TAG    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE     = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOT_LIVE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_LOOK,
    S_CHECK,
    S_SWAP,
    S_LINK,
    S_FREE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the accepted item
    logic sp_rd;       // read the sparse table
    logic sp_rd_last;  // sparse read at the id of the last dense entry
    logic dn_rd;       // read the dense table
    logic dn_rd_last;  // dense read at the last live slot
    logic create_wr;   // commit a create and post its result
    logic full_res;    // post a store-full result
    logic check_res;   // post a query or failed-delete result
    logic swap_wr;     // move the last dense entry into the hole
    logic link_wr;     // repoint the moved id at its new slot
    logic free_wr;     // push the deleted id and post the result
  } gha_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    action_t action;
    logic    full;
    logic    live;
  } gha_sts_t;

endpackage

`default_nettype wire

[rtl/gha_dpath.sv]
`default_nettype none

module gha_dpath #(
  parameter int ID_BITS  = gha_pkg::ID_BITS_DEF,
  parameter int GEN_BITS = gha_pkg::GEN_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gha_pkg::action_t              in_action,
  input  wire logic [gha_pkg::HANDLE_W-1:0]  in_handle,
  input  wire logic [gha_pkg::TAG_W-1:0]     in_tag,
  input  wire gha_pkg::gha_cmd_t             cmd,
  output gha_pkg::gha_sts_t                  sts,
  output gha_pkg::status_t                   res_status,
  output logic [gha_pkg::HANDLE_W-1:0]       res_handle,
  output logic [gha_pkg::TAG_W-1:0]          res_tag,
  output logic                               res_alive
);
  import gha_pkg::*;

  localparam int CAP  = 1 << ID_BITS;
  localparam int SP_W = ID_BITS + GEN_BITS;
  localparam int DN_W = ID_BITS + TAG_W;
  localparam logic [ID_BITS:0]    CNT_ONE = 1;
  localparam logic [GEN_BITS-1:0] GEN_ONE = 1;

  // Sparse: link (dense slot or next free id) above generation.
  // Dense: id above tag.
  logic [SP_W-1:0] sparse_mem [CAP];
  logic [DN_W-1:0] dense_mem  [CAP];

  logic [SP_W-1:0]     sp_rd_r;
  logic [DN_W-1:0]     dn_rd_r;
  action_t             action_r;
  logic [ID_BITS-1:0]  id_r;
  logic [GEN_BITS-1:0] gen_r;
  logic [TAG_W-1:0]    tag_r;
  logic [ID_BITS-1:0]  di_r;
  logic [GEN_BITS-1:0] g_r;

  logic [ID_BITS:0]    live_count_r, live_count_nxt;
  logic [ID_BITS:0]    free_count_r, free_count_nxt;
  logic [ID_BITS-1:0]  free_head_r, free_head_nxt;

  status_t             status_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [TAG_W-1:0]    tag_out_r;
  logic                alive_r;

  logic [HANDLE_W+ID_BITS-1:0] in_handle_ext;
  logic [ID_BITS-1:0]          in_id;
  logic [GEN_BITS-1:0]         in_gen;
  logic                        fresh;
  logic [ID_BITS-1:0]          nid;
  logic [ID_BITS-1:0]          sp_link;
  logic [GEN_BITS-1:0]         sp_gen;
  logic [GEN_BITS-1:0]         new_gen;
  logic [ID_BITS-1:0]          dn_id;
  logic [ID_BITS:0]            cnt_dec;
  logic [ID_BITS:0]            id_span;
  logic                        used;
  logic [ID_BITS-1:0]          sp_rd_addr, dn_rd_addr;
  logic                        sp_we, dn_we;
  logic [ID_BITS-1:0]          sp_wa, dn_wa;
  logic [SP_W-1:0]             sp_wd;
  logic [DN_W-1:0]             dn_wd;
  logic [SP_W+HANDLE_W-1:0]    new_handle_ext;
  logic                        live;

  // Split the incoming handle into id and generation
  assign in_handle_ext = {{ID_BITS{1'b0}}, in_handle} >> GEN_BITS;
  assign in_id         = in_handle_ext[ID_BITS-1:0];
  assign in_gen        = in_handle[GEN_BITS-1:0];

  // Pick the id for a create: free list head, or the next never-used id.
  // A never-used id has never been written, so its generation starts at zero.
  assign fresh   = (free_count_r == '0);
  assign nid     = fresh ? live_count_r[ID_BITS-1:0] : free_head_r;
  assign sp_link = sp_rd_r[SP_W-1:GEN_BITS];
  assign sp_gen  = sp_rd_r[GEN_BITS-1:0];
  assign new_gen = fresh ? '0 : sp_gen;
  assign dn_id   = dn_rd_r[DN_W-1:TAG_W];
  assign cnt_dec = live_count_r - CNT_ONE;

  assign new_handle_ext = {{HANDLE_W{1'b0}}, nid, new_gen};

  // Ids are handed out in order, so live plus free counts the ids ever used;
  // an id past that has an unwritten sparse entry and is never live
  assign id_span = live_count_r + free_count_r;
  assign used    = ({1'b0, id_r} < id_span);

  // Liveness of the looked-up handle
  assign live = used && ({1'b0, di_r} < live_count_r) && (dn_id == id_r) && (g_r == gen_r);

  // Read addresses
  always_comb begin
    if (cmd.sp_rd_last) begin
      sp_rd_addr = dn_id;
    end else if (in_action == ACT_CREATE) begin
      sp_rd_addr = nid;
    end else begin
      sp_rd_addr = in_id;
    end
    dn_rd_addr = cmd.dn_rd_last ? cnt_dec[ID_BITS-1:0] : sp_link;
  end

  // Write ports
  always_comb begin
    sp_we = 1'b0;
    sp_wa = nid;
    sp_wd = {live_count_r[ID_BITS-1:0], new_gen};
    dn_we = 1'b0;
    dn_wa = live_count_r[ID_BITS-1:0];
    dn_wd = {nid, tag_r};
    if (cmd.create_wr) begin
      sp_we = 1'b1;
      dn_we = 1'b1;
    end else if (cmd.swap_wr) begin
      dn_we = 1'b1;
      dn_wa = di_r;
      dn_wd = dn_rd_r;
    end else if (cmd.link_wr) begin
      sp_we = 1'b1;
      sp_wa = dn_id;
      sp_wd = {di_r, sp_gen};
    end else if (cmd.free_wr) begin
      sp_we = 1'b1;
      sp_wa = id_r;
      sp_wd = {free_head_r, g_r + GEN_ONE};
    end
  end

  // Table storage with registered reads
  always_ff @(posedge clk) begin
    if (sp_we) begin
      sparse_mem[sp_wa] <= sp_wd;
    end
    if (cmd.sp_rd) begin
      sp_rd_r <= sparse_mem[sp_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (dn_we) begin
      dense_mem[dn_wa] <= dn_wd;
    end
    if (cmd.dn_rd) begin
      dn_rd_r <= dense_mem[dn_rd_addr];
    end
  end

  // Next values of the counters and the free list head
  always_comb begin
    live_count_nxt = live_count_r;
    free_count_nxt = free_count_r;
    free_head_nxt  = free_head_r;
    if (cmd.create_wr) begin
      live_count_nxt = live_count_r + CNT_ONE;
      if (!fresh) begin
        free_count_nxt = free_count_r - CNT_ONE;
        free_head_nxt  = (free_count_r == CNT_ONE) ? '0 : sp_link;
      end
    end else if (cmd.free_wr) begin
      live_count_nxt = cnt_dec;
      free_count_nxt = free_count_r + CNT_ONE;
      free_head_nxt  = id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_count_r <= '0;
      free_count_r <= '0;
      free_head_r  <= '0;
    end else begin
      live_count_r <= live_count_nxt;
      free_count_r <= free_count_nxt;
      free_head_r  <= free_head_nxt;
    end
  end

  // Capture the item and the looked-up sparse fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      id_r     <= in_id;
      gen_r    <= in_gen;
      tag_r    <= in_tag;
    end
    if (cmd.dn_rd && !cmd.dn_rd_last) begin
      di_r <= sp_link;
      g_r  <= sp_gen;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.create_wr) begin
      status_r  <= STAT_DONE;
      handle_r  <= new_handle_ext[HANDLE_W-1:0];
      tag_out_r <= '0;
      alive_r   <= 1'b1;
    end else if (cmd.full_res) begin
      status_r  <= STAT_FULL;
      handle_r  <= '0;
      tag_out_r <= '0;
      alive_r   <= 1'b0;
    end else if (cmd.check_res) begin
      status_r  <= (!live && action_r != ACT_ALIVE) ? STAT_NOT_LIVE : STAT_DONE;
      handle_r  <= '0;
      tag_out_r <= (live && action_r == ACT_TAG) ? dn_rd_r[TAG_W-1:0] : '0;
      alive_r   <= live;
    end else if (cmd.free_wr) begin
      status_r  <= STAT_DONE;
      handle_r  <= '0;
      tag_out_r <= '0;
      alive_r   <= 1'b1;
    end
  end

  assign sts.action = action_r;
  assign sts.full   = live_count_r[ID_BITS];
  assign sts.live   = live;

  assign res_status = status_r;
  assign res_handle = handle_r;
  assign res_tag    = tag_out_r;
  assign res_alive  = alive_r;

endmodule

`default_nettype wire

[rtl/gha_ctrl.sv]
`default_nettype none

module gha_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire gha_pkg::action_t  in_action,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output gha_pkg::gha_cmd_t      cmd,
  input  wire gha_pkg::gha_sts_t sts
);
  import gha_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   finish;

  assign out_free = !out_valid_r || out_tready;

  // Sequence one item through the tables
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.sp_rd = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_action == ACT_CREATE) ? S_CREATE : S_LOOK;
        end
      end
      S_CREATE: begin
        if (out_free) begin
          if (sts.full) begin
            cmd.full_res = 1'b1;
          end else begin
            cmd.create_wr = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_LOOK: begin
        cmd.dn_rd = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.action == ACT_DELETE && sts.live) begin
          cmd.dn_rd      = 1'b1;
          cmd.dn_rd_last = 1'b1;
          state_nxt      = S_SWAP;
        end else if (out_free) begin
          cmd.check_res = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SWAP: begin
        cmd.swap_wr    = 1'b1;
        cmd.sp_rd      = 1'b1;
        cmd.sp_rd_last = 1'b1;
        state_nxt      = S_LINK;
      end
      S_LINK: begin
        cmd.link_wr = 1'b1;
        state_nxt   = S_FREE;
      end
      S_FREE: begin
        if (out_free) begin
          cmd.free_wr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  assign finish = cmd.create_wr || cmd.full_res || cmd.check_res || cmd.free_wr;

  always_comb begin
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

[rtl/generational_handle_allocator.sv]
// Generational handle allocator: hands out handles (id above generation) and
// keeps them in a sparse/dense table pair with a free list through the sparse
// table. Each input item carries an action (create, delete, query alive,
// query tag), a handle and a tag; each item produces exactly one result item
// with a status, a new handle, a tag and an alive bit.
// Input and result travel on stream channels (in_* and out_*); an item moves
// when tvalid and tready are both high.
// The block works on one item at a time. After the accepting edge, a create
// posts its result from S_CREATE, an alive/tag query walks S_LOOK and S_CHECK,
// and a delete walks S_LOOK, S_CHECK, S_SWAP, S_LINK and S_FREE; the result
// is registered as the item leaves its last state, and in_tready returns once
// the block is back in S_IDLE. The steps are set by the single-port sparse and
// dense memories: every lookup is a registered read that the next step depends
// on, and delete makes four dependent reads and three writes.
// The result sits in an output register, so a new item can be taken while a
// result waits; when the receiver stalls, the next item waits in its last
// step until the output register frees. After reset the counters are zero
// and the block is ready at once with no clearing pass: a handle whose id was
// never handed out is answered as not live from the counters alone.
`default_nettype none

module generational_handle_allocator #(
  parameter int ID_BITS  = gha_pkg::ID_BITS_DEF,
  parameter int GEN_BITS = gha_pkg::GEN_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // action[1:0], handle[17:2], tag_in[25:18], zero[31:26]
  input  wire logic [gha_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status[1:0], handle_out[17:2], tag_out[25:18], alive[26], zero[31:27]
  output logic [gha_pkg::OUT_TDATA_W-1:0]       out_tdata
);
  import gha_pkg::*;

  gha_cmd_t            cmd;
  gha_sts_t            sts;
  action_t             in_action;
  logic [HANDLE_W-1:0] in_handle;
  logic [TAG_W-1:0]    in_tag;
  status_t             res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [TAG_W-1:0]    res_tag;
  logic                res_alive;

  // Unpack the input item
  assign in_action = action_t'(in_tdata[ACTION_W-1:0]);
  assign in_handle = in_tdata[ACTION_W+HANDLE_W-1:ACTION_W];
  assign in_tag    = in_tdata[ACTION_W+HANDLE_W+TAG_W-1:ACTION_W+HANDLE_W];

  gha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_action),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  gha_dpath #(
    .ID_BITS  (ID_BITS),
    .GEN_BITS (GEN_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_action  (in_action),
    .in_handle  (in_handle),
    .in_tag     (in_tag),
    .cmd        (cmd),
    .sts        (sts),
    .res_status (res_status),
    .res_handle (res_handle),
    .res_tag    (res_tag),
    .res_alive  (res_alive)
  );

  // Pack the result item
  assign out_tdata = {5'b0, res_alive, res_tag, res_handle, res_status};

`ifndef SYNTHESIS
  // At most one result is posted per cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.create_wr, cmd.full_res, cmd.check_res, cmd.free_wr}))
    else $error("more than one result posted in a cycle");

  // A result is posted only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.create_wr || cmd.full_res || cmd.check_res || cmd.free_wr) |->
      (!out_tvalid || out_tready))
    else $error("result posted over a pending one");

  // An accepted item blocks the input until its result is posted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // The swap of the last dense entry is always followed by the relink
  a_swap_link: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap_wr |=> cmd.link_wr)
    else $error("dense swap not followed by sparse relink");
`endif

endmodule

`default_nettype wire
